FILE: rtl/hbbf_pkg.sv
// Shared types and constants of the high-boost box filter.
package hbbf_pkg;

   localparam int WINDOW = 3;
   localparam int RING = WINDOW + 1;
   localparam int AREA = WINDOW * WINDOW;

   localparam int PIX_W = 8;
   localparam int DIM_W = 11;
   localparam int GAIN_W = 4;
   localparam int BOOST_W = PIX_W + GAIN_W;
   localparam int SUM_W = $clog2(AREA * 255 + 1);

   // Division by the window area as a multiply by a rounded-up reciprocal;
   // exact for every window sum of 8-bit pixels.
   localparam int DIV_SHIFT = 16;
   localparam int DIV_RECIP = (2 ** DIV_SHIFT + AREA - 1) / AREA;
   localparam int RECIP_W = $clog2(DIV_RECIP + 1);
   localparam int PROD_W = SUM_W + RECIP_W;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST_GAIN = 2'd2;

   localparam int RESET_WIDTH = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int RESET_GAIN = 2;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_in;
      logic             is_flush;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] result_pixel;
      logic [PIX_W-1:0] blurred_pixel;
      logic [PIX_W-1:0] mask_pixel;
      logic             frame_last;
   } rsp_type;

endpackage

FILE: rtl/high_boost_box_filter.sv
// High-boost filter over a 3x3 box blur with line banks and a result pipeline.
//
// Usage: grey pixels enter on the req_ channel in raster order, one per beat;
// a beat with is_flush set carries no pixel and only lets a pending result out.
// Results leave on the rsp_ channel in raster order, carrying the sharpened,
// blurred and mask pixels and a flag on the last pixel of the frame. The csr_
// channel sets width, height and gain while the block is idle; the host keeps
// to that, since the block itself does not enforce it. A width or height write
// restarts the frame. Results trail the input by one row plus one column, so
// the host sends flush beats after a frame to drain it.
// Results pass the fetch, window, sum, blur and output registers. Throughput:
// one beat per clock on both channels while rsp_ready holds; the four line
// banks, each written once and read at two columns per cycle, set that rate.
// Reset: counters clear, width 640, height 480, gain 2, pipeline empty. The
// line banks are not cleared; only pixels of the current frame are read.
// When the receiver stalls, the result waits in the output register and the
// empty stages in front keep taking beats until the pipeline is full, then
// req_ready falls.
module high_boost_box_filter #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  hbbf_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output hbbf_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hbbf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hbbf_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int PW = hbbf_pkg::PIX_W;
   localparam int DW = hbbf_pkg::DIM_W;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int DIM_MAX = 2 ** DW - 1;
   localparam int WIDTH_CAP = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
   localparam int RESET_W_EFF =
      (hbbf_pkg::RESET_WIDTH < WIDTH_CAP) ? hbbf_pkg::RESET_WIDTH : WIDTH_CAP;
   localparam int RING = hbbf_pkg::RING;
   localparam int SLOT_W = $clog2(RING);
   localparam int WIN = hbbf_pkg::WINDOW;
   localparam int MID = hbbf_pkg::WINDOW / 2;
   localparam int ROW_LEAD = hbbf_pkg::WINDOW / 2 + 1;

   // Configuration, held as effective values.
   logic [DW-1:0]                  width_ff, height_ff, width_in, height_in;
   logic [hbbf_pkg::GAIN_W-1:0]    gain_ff;
   logic                           csr_write, restart;

   // Frame counters: input position and next output position.
   logic [DW-1:0]     col_ff, row_ff, er_ff, ec_ff;
   logic [SLOT_W-1:0] in_slot_ff, out_slot_ff;
   logic [DW-1:0]     col_in, row_in, er_in, ec_in, nr, nc, w_last, h_last, ec_next;
   logic [SLOT_W-1:0] in_slot_in, out_slot_in;
   logic              pix_write, col_wrap, ec_wrap, win_ready, emit, frame_end;

   // Handshake chain.
   logic en1, en2, en3, en4, en5, en_out, fire1, wr_en;

   // Stage 1: input register.
   logic          v1_ff, s1_flush_ff;
   logic [PW-1:0] s1_pix_ff;

   // Line banks and their read registers.
   logic [PW-1:0]     bank_mem [RING][MAX_WIDTH];
   logic [PW-1:0]     rda_ff [RING];
   logic [PW-1:0]     rdb_ff [RING];
   logic [COL_W-1:0]  wr_addr, rd_addr_a, rd_addr_b;
   logic              byp_a_ff, byp_b_ff;
   logic [SLOT_W-1:0] wr_slot_ff;
   logic [PW-1:0]     wr_pix_ff;

   // Stage 2: fetched columns.
   logic              v2_ff, s2_top_ok_ff, s2_bot_ok_ff, s2_right_ok_ff;
   logic              s2_row_start_ff, s2_last_ff;
   logic [SLOT_W-1:0] s2_slot_ff, slot_top, slot_bot;
   logic [PW-1:0]     col_a [RING];
   logic [PW-1:0]     col_b [RING];
   logic [WIN-1:0][PW-1:0] new_c, new_r;

   // Stage 3: window.
   logic                   v3_ff, s3_last_ff;
   logic [WIN-1:0][PW-1:0] wl_ff, wc_ff, wr_ff;
   logic [hbbf_pkg::SUM_W-1:0] sum_c;

   // Stage 4: window sum.
   logic                       v4_ff, s4_last_ff;
   logic [hbbf_pkg::SUM_W-1:0] sum4_ff;
   logic [PW-1:0]              src4_ff;
   logic [hbbf_pkg::PROD_W-1:0] blur_prod;

   // Stage 5: blur.
   logic          v5_ff, s5_last_ff;
   logic [PW-1:0] blur5_ff, src5_ff, mask_c, res_c;
   logic [hbbf_pkg::BOOST_W-1:0] boost_c;

   // Output register.
   logic              rsp_valid_ff;
   hbbf_pkg::rsp_type rsp_data_ff;

   // ---------------------------------------------------------------- config
   assign csr_ready = !reset;
   assign csr_write = csr_valid && csr_ready;
   assign restart = csr_write && (csr_index == hbbf_pkg::CSR_IMAGE_WIDTH ||
                                  csr_index == hbbf_pkg::CSR_IMAGE_HEIGHT);

   always_comb begin
      if (csr_data == '0) begin
         width_in = DW'(1);
      end else if (int'(csr_data) > WIDTH_CAP) begin
         width_in = DW'(WIDTH_CAP);
      end else begin
         width_in = csr_data;
      end
      height_in = (csr_data == '0) ? DW'(1) : csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= DW'(RESET_W_EFF);
         height_ff <= DW'(hbbf_pkg::RESET_HEIGHT);
         gain_ff <= hbbf_pkg::GAIN_W'(hbbf_pkg::RESET_GAIN);
      end else if (csr_write) begin
         unique case (csr_index)
            hbbf_pkg::CSR_IMAGE_WIDTH:  width_ff <= width_in;
            hbbf_pkg::CSR_IMAGE_HEIGHT: height_ff <= height_in;
            hbbf_pkg::CSR_BOOST_GAIN:   gain_ff <= csr_data[hbbf_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------ handshake
   assign en_out = !rsp_valid_ff || rsp_ready;
   assign en5 = !v5_ff || en_out;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1 && !reset;
   assign fire1 = v1_ff && en2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && req_valid) begin
         s1_pix_ff <= req_data.pixel_in;
         s1_flush_ff <= req_data.is_flush;
      end
   end

   // ------------------------------------------------------ frame counters
   // The pixel is stored first; readiness of the next output is judged on
   // the counters after that store.
   always_comb begin
      w_last = width_ff - DW'(1);
      h_last = height_ff - DW'(1);
      pix_write = v1_ff && !s1_flush_ff && (row_ff < height_ff);
      col_wrap = (col_ff == w_last);
      col_in = col_ff;
      row_in = row_ff;
      in_slot_in = in_slot_ff;
      if (pix_write) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + DW'(1);
            in_slot_in = (in_slot_ff == SLOT_W'(RING - 1)) ? '0 : in_slot_ff + SLOT_W'(1);
         end else begin
            col_in = col_ff + DW'(1);
         end
      end
      ec_next = ec_ff + DW'(1);
      ec_wrap = (ec_ff == w_last);
      nr = (er_ff == h_last) ? er_ff : er_ff + DW'(1);
      nc = ec_wrap ? ec_ff : ec_next;
      win_ready = (row_in > nr) || (row_in == nr && col_in > nc);
      emit = v1_ff && win_ready;
      frame_end = emit && (er_ff == h_last) && ec_wrap;
      er_in = er_ff;
      ec_in = ec_ff;
      out_slot_in = out_slot_ff;
      if (emit) begin
         if (ec_wrap) begin
            ec_in = '0;
            er_in = er_ff + DW'(1);
            out_slot_in = (out_slot_ff == SLOT_W'(RING - 1)) ? '0 : out_slot_ff + SLOT_W'(1);
         end else begin
            ec_in = ec_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart || (fire1 && frame_end)) begin
         col_ff <= '0;
         row_ff <= '0;
         er_ff <= '0;
         ec_ff <= '0;
         in_slot_ff <= '0;
         out_slot_ff <= '0;
      end else if (fire1) begin
         col_ff <= col_in;
         row_ff <= row_in;
         er_ff <= er_in;
         ec_ff <= ec_in;
         in_slot_ff <= in_slot_in;
         out_slot_ff <= out_slot_in;
      end
   end

   // ----------------------------------------------------------- line banks
   // Each bank holds one image row; the output side reads the center and
   // right columns of all banks, and a same-cycle store is forwarded.
   assign wr_en = fire1 && pix_write;
   assign wr_addr = COL_W'(col_ff);
   assign rd_addr_a = COL_W'(ec_ff);
   assign rd_addr_b = COL_W'(ec_next);

   always_ff @(posedge clock) begin
      for (int b = 0; b < RING; b++) begin
         if (wr_en && in_slot_ff == SLOT_W'(b)) begin
            bank_mem[b][wr_addr] <= s1_pix_ff;
         end
         if (en2) begin
            rda_ff[b] <= bank_mem[b][rd_addr_a];
            rdb_ff[b] <= bank_mem[b][rd_addr_b];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         byp_a_ff <= wr_en && (col_ff == ec_ff);
         byp_b_ff <= wr_en && (col_ff == ec_next);
         wr_slot_ff <= in_slot_ff;
         wr_pix_ff <= s1_pix_ff;
         s2_slot_ff <= out_slot_ff;
         s2_top_ok_ff <= (er_ff != '0);
         s2_bot_ok_ff <= (er_ff != h_last);
         s2_right_ok_ff <= !ec_wrap;
         s2_row_start_ff <= (ec_ff == '0);
         s2_last_ff <= frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= emit;
      end
   end

   // --------------------------------------------------------- column fetch
   always_comb begin
      for (int b = 0; b < RING; b++) begin
         col_a[b] = (byp_a_ff && wr_slot_ff == SLOT_W'(b)) ? wr_pix_ff : rda_ff[b];
         col_b[b] = (byp_b_ff && wr_slot_ff == SLOT_W'(b)) ? wr_pix_ff : rdb_ff[b];
      end
      slot_top = (s2_slot_ff == '0) ? SLOT_W'(RING - 1) : s2_slot_ff - SLOT_W'(1);
      slot_bot = (s2_slot_ff == SLOT_W'(RING - 1)) ? '0 : s2_slot_ff + SLOT_W'(1);
      new_c[0] = s2_top_ok_ff ? col_a[slot_top] : '0;
      new_c[1] = col_a[s2_slot_ff];
      new_c[2] = s2_bot_ok_ff ? col_a[slot_bot] : '0;
      new_r[0] = (s2_right_ok_ff && s2_top_ok_ff) ? col_b[slot_top] : '0;
      new_r[1] = s2_right_ok_ff ? col_b[s2_slot_ff] : '0;
      new_r[2] = (s2_right_ok_ff && s2_bot_ok_ff) ? col_b[slot_bot] : '0;
   end

   // --------------------------------------------------------------- window
   // The left column is the previous center column of the same row, or the
   // zero border at the start of a row.
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && v2_ff) begin
         wl_ff <= s2_row_start_ff ? '0 : wc_ff;
         wc_ff <= new_c;
         wr_ff <= new_r;
         s3_last_ff <= s2_last_ff;
      end
   end

   always_comb begin
      sum_c = '0;
      for (int i = 0; i < WIN; i++) begin
         sum_c = sum_c + hbbf_pkg::SUM_W'(wl_ff[i]) + hbbf_pkg::SUM_W'(wc_ff[i])
               + hbbf_pkg::SUM_W'(wr_ff[i]);
      end
   end

   // ------------------------------------------------------ sum and blur
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en4) begin
            v4_ff <= v3_ff;
         end
         if (en5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   assign blur_prod = hbbf_pkg::PROD_W'(sum4_ff) * hbbf_pkg::PROD_W'(hbbf_pkg::DIV_RECIP);

   always_ff @(posedge clock) begin
      if (en4 && v3_ff) begin
         sum4_ff <= sum_c;
         src4_ff <= wc_ff[MID];
         s4_last_ff <= s3_last_ff;
      end
      if (en5 && v4_ff) begin
         blur5_ff <= blur_prod[hbbf_pkg::DIV_SHIFT +: PW];
         src5_ff <= src4_ff;
         s5_last_ff <= s4_last_ff;
      end
   end

   // --------------------------------------------------- mask and result
   always_comb begin
      mask_c = (src5_ff > blur5_ff) ? src5_ff - blur5_ff : '0;
      boost_c = hbbf_pkg::BOOST_W'(src5_ff)
              + hbbf_pkg::BOOST_W'(gain_ff) * hbbf_pkg::BOOST_W'(mask_c);
      res_c = (boost_c[hbbf_pkg::BOOST_W-1:PW] != '0) ? '1 : boost_c[PW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out && v5_ff) begin
         rsp_data_ff.result_pixel <= res_c;
         rsp_data_ff.blurred_pixel <= blur5_ff;
         rsp_data_ff.mask_pixel <= mask_c;
         rsp_data_ff.frame_last <= s5_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

`ifndef ASSERT_OFF
   // The input column always lies inside the configured row.
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      col_ff < width_ff)
      else $error("input column reached the row width");

   // Outputs never run ahead of the rows received.
   a_out_behind_in: assert property (@(posedge clock) disable iff (reset)
      er_ff <= row_ff)
      else $error("output row passed the input row");

   // The input never laps the banks still needed by the output window.
   a_ring_lead: assert property (@(posedge clock) disable iff (reset)
      {1'b0, row_ff} <= {1'b0, er_ff} + (DW + 1)'(ROW_LEAD))
      else $error("input row overran the line banks");
`endif

endmodule
